// ===== rtl/core/sfe_pkg.sv =====
`timescale 1ns / 1ps
// sfe_pkg: shared types and constants for the stereo feedforward echo
// used by sfe_mix and stereo_feedforward_echo; no dependencies
package sfe_pkg;

   // gain is q1.15, unity is 16'h8000 and the echo clamps larger gains to unity
   localparam int GAIN_FRAC_BITS = 15;
   localparam logic [15:0] GAIN_UNITY = 16'h8000;
   localparam logic [15:0] FRAMES_SEEN_MAX = 16'hFFFF;

   // register index, taken from paddr[2]
   localparam logic [0:0] REG_DELAY_LENGTH = 1'b0;
   localparam logic [0:0] REG_DECAY_GAIN = 1'b1;

   localparam logic [14:0] DELAY_RESET = 15'd0;
   localparam logic [15:0] GAIN_RESET = 16'd16384;

   typedef enum logic [1:0] {
      MODE_DRY,
      MODE_SELF,
      MODE_ECHO
   } echo_mode_type;

   typedef struct packed {
      logic load_mult;
      logic load_out;
   } mix_ctrl_type;

endpackage

// ===== rtl/core/stereo_feedforward_echo.sv =====
`timescale 1ns / 1ps
// stereo_feedforward_echo: feedforward comb echo on a stereo frame stream
// rsp_valid rises once the accepted frame has passed the read, multiply and mix stages;
// one frame per cycle sustained, set by the single history memory read and write done
// at accept; a stalled rsp_ready holds every stage
// synchronous active-high reset clears pointers, counters, valids and config registers;
// the history memory is not cleared and needs no clearing pass
// depends on sfe_pkg and sfe_mix
module stereo_feedforward_echo import sfe_pkg::*; #(
   parameter int MAX_DELAY_FRAMES = 32768,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  logic                          req_clip_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int AW  = $clog2(MAX_DELAY_FRAMES);
   localparam int AW1 = AW + 1;
   localparam int FW  = 2 * SAMPLE_BITS;

   logic [FW-1:0] hist_mem [MAX_DELAY_FRAMES];

   logic [14:0] delay_ff;
   logic [15:0] gain_ff;
   logic [0:0]  reg_idx;
   logic        csr_write;

   logic [AW-1:0] wp_ff, wp_in;
   logic [15:0]   fs_ff, fs_in, fs_eff;

   logic [14:0]   dly_eff;
   logic [AW-1:0] dly_addr;
   logic [AW:0]   diff;
   logic [AW-1:0] rd_addr;
   logic [15:0]   gain_eff;
   echo_mode_type mode_in;

   logic                          v1_ff, v2_ff, v3_ff;
   logic                          ready1, ready2, ready3;
   logic                          accept;
   logic signed [SAMPLE_BITS-1:0] xl1_ff, xr1_ff;
   logic [FW-1:0]                 rd_data_ff;
   echo_mode_type                 mode1_ff;
   logic [15:0]                   gain1_ff;

   logic signed [SAMPLE_BITS-1:0] src_l, src_r;
   logic [15:0]                   lane_gain;
   mix_ctrl_type                  ctrl;

   // configuration
   assign pready    = 1'b1;
   assign reg_idx   = paddr[2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET;
         gain_ff  <= GAIN_RESET;
      end else if (csr_write) begin
         case (reg_idx)
            REG_DELAY_LENGTH: delay_ff <= pwdata[14:0];
            REG_DECAY_GAIN:   gain_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DELAY_LENGTH: prdata = {17'd0, delay_ff};
         REG_DECAY_GAIN:   prdata = {16'd0, gain_ff};
         default:          prdata = '0;
      endcase
   end

   // pipeline handshake
   assign ready3    = !v3_ff || rsp_ready;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign req_ready = ready1;
   assign accept    = req_valid && ready1;
   assign rsp_valid = v3_ff;

   // address and mode for the incoming word
   always_comb begin
      dly_eff  = (32'(delay_ff) > MAX_DELAY_FRAMES - 1) ?
                 15'(MAX_DELAY_FRAMES - 1) : delay_ff;
      dly_addr = AW'(dly_eff);
      diff     = {1'b0, wp_ff} - AW1'(dly_addr);
      rd_addr  = diff[AW] ? AW'(diff + AW1'(MAX_DELAY_FRAMES)) : AW'(diff);
      fs_eff   = req_clip_start ? 16'd0 : fs_ff;
      gain_eff = (gain_ff > GAIN_UNITY) ? GAIN_UNITY : gain_ff;
      if (dly_eff == '0) begin
         mode_in = MODE_SELF;
      end else if (fs_eff < {1'b0, dly_eff}) begin
         mode_in = MODE_DRY;
      end else begin
         mode_in = MODE_ECHO;
      end
      wp_in = (32'(wp_ff) == MAX_DELAY_FRAMES - 1) ? '0 : wp_ff + AW'(1);
      fs_in = (fs_eff == FRAMES_SEEN_MAX) ? fs_eff : fs_eff + 16'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         fs_ff <= '0;
      end else if (accept) begin
         wp_ff <= wp_in;
         fs_ff <= fs_in;
      end
   end

   // history memory, read and write at accept; an echo read never targets the write slot
   always_ff @(posedge clock) begin
      if (accept) begin
         hist_mem[wp_ff] <= {req_left_sample, req_right_sample};
         rd_data_ff      <= hist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= req_valid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode1_ff <= MODE_DRY;
      end else if (accept) begin
         mode1_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         xl1_ff   <= req_left_sample;
         xr1_ff   <= req_right_sample;
         gain1_ff <= gain_eff;
      end
   end

   // echo source per mode; a dry word gets zero gain
   always_comb begin
      case (mode1_ff)
         MODE_SELF: begin
            src_l     = xl1_ff;
            src_r     = xr1_ff;
            lane_gain = gain1_ff;
         end
         MODE_ECHO: begin
            src_l     = rd_data_ff[FW-1:SAMPLE_BITS];
            src_r     = rd_data_ff[SAMPLE_BITS-1:0];
            lane_gain = gain1_ff;
         end
         default: begin
            src_l     = xl1_ff;
            src_r     = xr1_ff;
            lane_gain = 16'd0;
         end
      endcase
   end

   assign ctrl.load_mult = ready2;
   assign ctrl.load_out  = ready3;

   sfe_mix #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_mix_left (
      .clock (clock),
      .ctrl  (ctrl),
      .dry_i (xl1_ff),
      .src_i (src_l),
      .gain_i(lane_gain),
      .mix_o (rsp_left_out)
   );

   sfe_mix #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_mix_right (
      .clock (clock),
      .ctrl  (ctrl),
      .dry_i (xr1_ff),
      .src_i (src_r),
      .gain_i(lane_gain),
      .mix_o (rsp_right_out)
   );

   // checks
   a_rd_not_wr: assert property (@(posedge clock) disable iff (reset)
      (accept && (mode_in == MODE_ECHO)) |-> (rd_addr != wp_ff))
      else $error("echo read hits the slot being written");

   a_wp_step: assert property (@(posedge clock) disable iff (reset)
      accept |=> (wp_ff == ((32'($past(wp_ff)) == MAX_DELAY_FRAMES - 1) ?
                            '0 : $past(wp_ff) + AW'(1))))
      else $error("write pointer did not advance by one");

   a_clip_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_clip_start) |=> (fs_ff == 16'd1))
      else $error("frame count not restarted on clip start");

   a_fs_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(fs_ff) && $stable(wp_ff))
      else $error("history state moved without an accepted word");

endmodule

// ===== rtl/core/sfe_mix.sv =====
`timescale 1ns / 1ps
// sfe_mix: one channel lane, registered gain multiply then round toward zero,
// add and saturate; depends on sfe_pkg
module sfe_mix import sfe_pkg::*; #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  mix_ctrl_type                  ctrl,
   input  logic signed [SAMPLE_BITS-1:0] dry_i,
   input  logic signed [SAMPLE_BITS-1:0] src_i,
   input  logic [15:0]                   gain_i,
   output logic signed [SAMPLE_BITS-1:0] mix_o
);

   localparam int PW = SAMPLE_BITS + 17;
   localparam int SW = SAMPLE_BITS + 2;

   logic signed [PW-1:0]          prod_in, prod_ff;
   logic signed [SAMPLE_BITS-1:0] dry_ff;
   logic signed [PW-1:0]          biased;
   logic signed [SW-1:0]          scaled, sum;
   logic signed [SAMPLE_BITS-1:0] mix_in, mix_ff;

   assign prod_in = $signed({1'b0, gain_i}) * src_i;

   always_ff @(posedge clock) begin
      if (ctrl.load_mult) begin
         prod_ff <= prod_in;
         dry_ff  <= dry_i;
      end
      if (ctrl.load_out) begin
         mix_ff <= mix_in;
      end
   end

   always_comb begin
      // bias negative products so the arithmetic shift truncates toward zero
      biased = prod_ff[PW-1] ? prod_ff + PW'((1 << GAIN_FRAC_BITS) - 1) : prod_ff;
      scaled = biased[GAIN_FRAC_BITS +: SW];
      sum    = SW'(dry_ff) + scaled;
      if ((sum[SW-1:SAMPLE_BITS-1] == '0) || (sum[SW-1:SAMPLE_BITS-1] == '1)) begin
         mix_in = sum[SAMPLE_BITS-1:0];
      end else if (sum[SW-1]) begin
         mix_in = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         mix_in = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   assign mix_o = mix_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for stereo_feedforward_echo, directed table then random clips
// depends on sfe_pkg and the stereo_feedforward_echo rtl; needs no files or arguments
module tb_top;
   import sfe_pkg::*;

   localparam int DEPTH = 32768;
   localparam int LATENCY = 3;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int PLAN_ROWS = 23;
   localparam int PHASES = 7;
   localparam int SHOW_MAX = 40;
   // gain picks for the random phases
   localparam int GAIN_PICK = -1;
   localparam int GAIN_OVER = -2;

   typedef logic signed [15:0] sample_type;
   typedef struct {
      sample_type left;
      sample_type right;
   } frame_out_type;
   typedef enum { ROW_FRAME, ROW_REG } row_kind_type;
   typedef struct {
      row_kind_type kind;
      logic [0:0]   reg_idx;
      int           value;
      int           left;
      int           right;
      bit           clip;
      bit           typed;
      int           exp_l;
      int           exp_r;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   sample_type  req_left_sample = '0;
   sample_type  req_right_sample = '0;
   logic        req_clip_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   sample_type  rsp_left_out;
   sample_type  rsp_right_out;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   stereo_feedforward_echo uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .req_clip_start   (req_clip_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // own copy of the echo state
   sample_type    tap_left [DEPTH];
   sample_type    tap_right [DEPTH];
   logic [14:0]   wr_slot = '0;
   logic [15:0]   clip_frames = '0;
   logic [14:0]   echo_delay = DELAY_RESET;
   logic [15:0]   echo_gain = GAIN_RESET;
   frame_out_type echo_due [$];

   int errors = 0;
   int shown = 0;
   int cycles = 0;
   bit calm = 1'b0;
   int burst_left = 0;
   int stall_pct = 0;
   int stall_run = 0;

   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, 0, 0, 1'b1, 1'b1, 0, 0},
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, 32767, -32768, 1'b0, 1'b1, 32767, -32768},
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, -32768, 32767, 1'b0, 1'b1, -32768, 32767},
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, 1, -1, 1'b0, 1'b1, 1, -1},
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, 100, -3, 1'b0, 1'b1, 150, -4},
      '{ROW_REG, REG_DECAY_GAIN, 0, 0, 0, 1'b0, 1'b0, 0, 0},
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, 12345, -12345, 1'b0, 1'b1, 12345, -12345},
      // gain above unity acts as unity
      '{ROW_REG, REG_DECAY_GAIN, 65535, 0, 0, 1'b0, 1'b0, 0, 0},
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, 1000, -1000, 1'b0, 1'b1, 2000, -2000},
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, 20000, -20000, 1'b0, 1'b1, 32767, -32768},
      '{ROW_REG, REG_DECAY_GAIN, 32768, 0, 0, 1'b0, 1'b0, 0, 0},
      '{ROW_REG, REG_DELAY_LENGTH, 2, 0, 0, 1'b0, 1'b0, 0, 0},
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, 10, 20, 1'b1, 1'b1, 10, 20},
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, 30, 40, 1'b0, 1'b1, 30, 40},
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, 5, 6, 1'b0, 1'b1, 15, 26},
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, 32767, -32768, 1'b0, 1'b1, 32767, -32728},
      // new clip goes dry again
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, 7, 8, 1'b1, 1'b1, 7, 8},
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, 1, 1, 1'b0, 1'b1, 1, 1},
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, 2, 2, 1'b0, 1'b1, 9, 10},
      '{ROW_REG, REG_DELAY_LENGTH, 1, 0, 0, 1'b0, 1'b0, 0, 0},
      '{ROW_REG, REG_DECAY_GAIN, 16384, 0, 0, 1'b0, 1'b0, 0, 0},
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, -32768, -32768, 1'b0, 1'b0, 0, 0},
      '{ROW_FRAME, REG_DELAY_LENGTH, 0, -1, 32767, 1'b0, 1'b0, 0, 0}
   };

   // last phase holds the longest delay, so every word of it passes dry
   int ph_delay [PHASES] = '{0, 1, 3, 16, 37, 250, 32767};
   int ph_gain [PHASES] = '{GAIN_PICK, 32768, GAIN_PICK, 0, GAIN_OVER, GAIN_PICK, GAIN_PICK};
   int ph_frames [PHASES] = '{100, 100, 120, 80, 120, 300, 30};
   int ph_clip_odds [PHASES] = '{10, 20, 30, 50, 60, 400, 0};

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic sample_type mix_tap(sample_type x, sample_type xd, logic [15:0] gain);
      int p;
      int s;
      p = int'(gain) * int'(xd);
      s = int'(x) + p / (1 << GAIN_FRAC_BITS);
      if (s > 32767) s = 32767;
      else if (s < -32768) s = -32768;
      return sample_type'(s);
   endfunction

   function automatic frame_out_type predict_echo(sample_type xl, sample_type xr, bit clip);
      frame_out_type o;
      logic [15:0]   g;
      logic [14:0]   rd_slot;
      g = (echo_gain > GAIN_UNITY) ? GAIN_UNITY : echo_gain;
      if (clip) clip_frames = '0;
      rd_slot = wr_slot - echo_delay;
      if (echo_delay == 15'd0) begin
         o.left = mix_tap(xl, xl, g);
         o.right = mix_tap(xr, xr, g);
      end else if (clip_frames < {1'b0, echo_delay}) begin
         o.left = xl;
         o.right = xr;
      end else begin
         o.left = mix_tap(xl, tap_left[rd_slot], g);
         o.right = mix_tap(xr, tap_right[rd_slot], g);
      end
      tap_left[wr_slot] = xl;
      tap_right[wr_slot] = xr;
      wr_slot = wr_slot + 15'd1;
      if (clip_frames != FRAMES_SEEN_MAX) clip_frames = clip_frames + 16'd1;
      return o;
   endfunction

   function automatic sample_type pick_sample();
      logic [15:0] v;
      int k;
      k = $urandom_range(0, 9);
      v = 16'($urandom);
      if (k == 0) v = 16'h7FFF;
      else if (k == 1) v = 16'h8000;
      else if (k < 4) v = 16'($urandom_range(0, 64)) - 16'd32;
      return $signed(v);
   endfunction

   function automatic void check_field(string what, sample_type want, sample_type got);
      if (got !== want) begin
         errors++;
         if (shown < SHOW_MAX) begin
            shown++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         end
      end
   endfunction

   task automatic write_reg(logic [0:0] idx, logic [31:0] value);
      logic [31:0] mask;
      mask = (idx == REG_DELAY_LENGTH) ? 32'h7FFF : 32'hFFFF;
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == REG_DELAY_LENGTH) echo_delay = value[14:0];
      else echo_gain = value[15:0];
      // read back what was just written
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if ((prdata & mask) !== (value & mask)) begin
         errors++;
         $display("%0t: register %0d expected %0h, got %0h", $time, idx, value & mask,
                  prdata & mask);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (echo_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic send_frame(sample_type xl, sample_type xr, bit clip, bit typed,
                             sample_type el, sample_type er);
      frame_out_type o;
      if (burst_left == 0) begin
         burst_left = calm ? $urandom_range(50, 400) : $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat (calm ? 1 : $urandom_range(1, 8)) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_left_sample <= xl;
      req_right_sample <= xr;
      req_clip_start <= clip;
      do @(posedge clock); while (!req_ready);
      o = predict_echo(xl, xr, clip);
      if (typed) begin
         o.left = el;
         o.right = er;
      end
      echo_due.push_back(o);
      burst_left--;
   endtask

   // receiver: stall pattern in segments, some with no stalls at all
   always @(posedge clock) begin : rsp_watch
      frame_out_type want;
      if (stall_run == 0) begin
         stall_run = $urandom_range(20, 200);
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 80;
         endcase
         if (calm) stall_pct = stall_pct / 8;
      end
      stall_run--;
      if (!reset && rsp_valid && rsp_ready) begin
         if (echo_due.size() == 0) begin
            errors++;
            if (shown < SHOW_MAX) begin
               shown++;
               $display("%0t: word with nothing due, expected none, got %0d / %0d", $time,
                        rsp_left_out, rsp_right_out);
            end
         end else begin
            want = echo_due.pop_front();
            check_field("left_out", want.left, rsp_left_out);
            check_field("right_out", want.right, rsp_right_out);
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      int i;
      int p;
      int n;
      int odds;
      bit clip;
      logic [31:0] gain;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (i = 0; i < PLAN_ROWS; i++) begin
         if (plan[i].kind == ROW_REG) begin
            drain();
            write_reg(plan[i].reg_idx, plan[i].value);
         end else begin
            send_frame(sample_type'(plan[i].left), sample_type'(plan[i].right), plan[i].clip,
                       plan[i].typed, sample_type'(plan[i].exp_l),
                       sample_type'(plan[i].exp_r));
         end
      end
      for (p = 0; p < PHASES; p++) begin
         drain();
         calm = (ph_frames[p] > 1000);
         case (ph_gain[p])
            GAIN_PICK: gain = $urandom_range(0, 32768);
            GAIN_OVER: gain = $urandom_range(32769, 65535);
            default: gain = ph_gain[p];
         endcase
         write_reg(REG_DELAY_LENGTH, ph_delay[p]);
         write_reg(REG_DECAY_GAIN, gain);
         odds = ph_clip_odds[p];
         for (n = 0; n < ph_frames[p]; n++) begin
            clip = (odds == 0) ? (n == 0) : ($urandom_range(1, odds) == 1);
            send_frame(pick_sample(), pick_sample(), clip, 1'b0, '0, '0);
         end
      end
      drain();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
